/* hdl/geohash_cell_unit_top_defines.svh */
// Assertion macros shared by the geohash cell unit RTL.
`ifndef GEOHASH_CELL_UNIT_TOP_DEFINES_SVH
`define GEOHASH_CELL_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GHC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GHC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ghc_pkg.sv */
// Package with the request and result types, opcodes and bit-routing helpers.
`default_nettype none
package ghc_pkg;

  localparam logic [5:0] AXIS_BITS = 6'd32;

  typedef enum logic [2:0] {
    OP_ENCODE = 3'd0,
    OP_DECODE = 3'd1,
    OP_STEP_X = 3'd2,
    OP_STEP_Y = 3'd3,
    OP_PREFIX = 3'd4,
    OP_PARENT = 3'd5
  } ghc_op_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [31:0]       x_coord;
    logic [31:0]       y_coord;
    logic [63:0]       hash_in;
    logic [5:0]        precision;
    logic signed [1:0] step_dir;
    logic [63:0]       other_hash;
  } ghc_req_t;

  typedef struct packed {
    logic [63:0] hash_out;
    logic [5:0]  precision_out;
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic        prefix_match;
    logic        wrapped;
    logic        invalid;
  } ghc_rsp_t;

  // Mask of the top 2*p hash bits; p is at most 32.
  function automatic logic [63:0] top_mask(input logic [5:0] p);
    logic [6:0] sh;
    sh = 7'd64 - {p, 1'b0};
    if (p == 6'd0) begin
      return 64'd0;
    end
    return ~64'd0 << sh;
  endfunction

  // x bits land on odd hash positions, y bits on even ones.
  function automatic logic [63:0] interleave(input logic [31:0] x, input logic [31:0] y);
    logic [63:0] h;
    for (int k = 0; k < 32; k++) begin
      h[2*k+1] = x[k];
      h[2*k]   = y[k];
    end
    return h;
  endfunction

  function automatic logic [31:0] gather(input logic [63:0] h, input logic lane_y);
    logic [31:0] c;
    for (int k = 0; k < 32; k++) begin
      c[k] = lane_y ? h[2*k] : h[2*k+1];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/ghc_req_if.sv */
// Request channel interface of the geohash cell unit.
`default_nettype none
interface ghc_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [31:0]       x_coord;
  logic [31:0]       y_coord;
  logic [63:0]       hash_in;
  logic [5:0]        precision;
  logic signed [1:0] step_dir;
  logic [63:0]       other_hash;

  modport source (output valid, opcode, x_coord, y_coord, hash_in, precision, step_dir,
                  other_hash, input ready);
  modport sink (input valid, opcode, x_coord, y_coord, hash_in, precision, step_dir,
                other_hash, output ready);
endinterface
`default_nettype wire

/* hdl/ghc_rsp_if.sv */
// Result channel interface of the geohash cell unit.
`default_nettype none
interface ghc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_out;
  logic [5:0]  precision_out;
  logic [31:0] x_out;
  logic [31:0] y_out;
  logic        prefix_match;
  logic        wrapped;
  logic        invalid;

  modport source (output valid, hash_out, precision_out, x_out, y_out, prefix_match,
                  wrapped, invalid, input ready);
  modport sink (input valid, hash_out, precision_out, x_out, y_out, prefix_match,
                wrapped, invalid, output ready);
endinterface
`default_nettype wire

/* hdl/ghc_core.sv */
// Combinational datapath: encode, decode, step, prefix test and parent.
`default_nettype none
module ghc_core (
  input  ghc_pkg::ghc_req_t req,
  output ghc_pkg::ghc_rsp_t rsp
);
  import ghc_pkg::*;

  logic [5:0]  p;
  logic [63:0] mask;
  logic [63:0] hm;
  logic [31:0] xs;
  logic [31:0] ys;
  logic        lane_y;
  logic [31:0] c;
  logic [31:0] inc;
  logic [5:0]  inc_sh;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [31:0] nc;
  logic        wrap;
  logic [63:0] step_hash;

  assign p      = (req.precision > AXIS_BITS) ? AXIS_BITS : req.precision;
  assign mask   = top_mask(p);
  assign hm     = req.hash_in & mask;
  assign xs     = gather(hm, 1'b0);
  assign ys     = gather(hm, 1'b1);
  assign lane_y = (req.opcode == OP_STEP_Y);
  assign c      = lane_y ? ys : xs;

  // One unit at the lowest significant bit of the axis; the bits under it are zero.
  assign inc_sh = 6'd32 - p;
  assign inc    = 32'd1 << inc_sh;
  assign sum    = {1'b0, c} + {1'b0, inc};
  assign diff   = {1'b0, c} - {1'b0, inc};

  always_comb begin
    nc   = c;
    wrap = 1'b0;
    if (req.step_dir == 2'sb01) begin
      nc   = sum[31:0];
      wrap = sum[32];
    end else if (req.step_dir[1]) begin
      // Both negative codes step down.
      nc   = diff[31:0];
      wrap = diff[32];
    end
  end

  assign step_hash = (lane_y ? interleave(xs, nc) : interleave(nc, ys)) & mask;

  always_comb begin
    rsp = '0;
    case (req.opcode)
      OP_ENCODE: begin
        rsp.hash_out      = interleave(req.x_coord, req.y_coord) & mask;
        rsp.precision_out = p;
      end
      OP_DECODE: begin
        rsp.hash_out      = hm;
        rsp.precision_out = p;
        rsp.x_out         = xs;
        rsp.y_out         = ys;
      end
      OP_STEP_X, OP_STEP_Y: begin
        if (p == 6'd0) begin
          rsp.invalid = 1'b1;
        end else begin
          rsp.hash_out      = step_hash;
          rsp.precision_out = p;
          rsp.wrapped       = wrap;
        end
      end
      OP_PREFIX: begin
        rsp.prefix_match  = (((req.hash_in ^ req.other_hash) & mask) == 64'd0);
        rsp.precision_out = p;
      end
      OP_PARENT: begin
        if (p == 6'd0) begin
          rsp.invalid = 1'b1;
        end else begin
          rsp.hash_out      = req.hash_in & top_mask(p - 6'd1);
          rsp.precision_out = p - 6'd1;
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end
endmodule
`default_nettype wire

/* hdl/geohash_cell_unit_top.sv */
// Top level of the geohash cell unit: request register, datapath, result register.
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid / ready | opcode, coords, hash, precision, step, other hash
//  out_ch  | out | valid / ready | hash, precision, x, y, match, wrapped, invalid
//
// Each request passes through the request register and then the result register
// before its result is valid. With the result side ready, a new request is
// accepted every cycle. A stalled result holds in its register while the request
// register can still take one more request. Reset clears both stage valid flags;
// there is no clearing pass.
`default_nettype none
module geohash_cell_unit_top (
  input  wire        clk,
  input  wire        rst_n,
  ghc_req_if.sink    in_ch,
  ghc_rsp_if.source  out_ch
);
  import ghc_pkg::*;
  `include "geohash_cell_unit_top_defines.svh"

  logic     s1_v_r;
  logic     s1_v_nxt;
  ghc_req_t s1_req_r;
  ghc_req_t in_req;
  logic     out_v_r;
  logic     out_v_nxt;
  ghc_rsp_t out_rsp_r;
  ghc_rsp_t core_rsp;
  logic     s2_take;
  logic     in_take;

  assign in_req.opcode     = in_ch.opcode;
  assign in_req.x_coord    = in_ch.x_coord;
  assign in_req.y_coord    = in_ch.y_coord;
  assign in_req.hash_in    = in_ch.hash_in;
  assign in_req.precision  = in_ch.precision;
  assign in_req.step_dir   = in_ch.step_dir;
  assign in_req.other_hash = in_ch.other_hash;

  // The result register frees up when empty or when its request leaves.
  assign s2_take     = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || s2_take;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt  = in_take ? 1'b1 : (s2_take ? 1'b0 : s1_v_r);
    out_v_nxt = s2_take ? s1_v_r : out_v_r;
  end

  ghc_core u_core (
    .req (s1_req_r),
    .rsp (core_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r <= in_req;
    end
    if (s2_take && s1_v_r) begin
      out_rsp_r <= core_rsp;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.hash_out      = out_rsp_r.hash_out;
  assign out_ch.precision_out = out_rsp_r.precision_out;
  assign out_ch.x_out         = out_rsp_r.x_out;
  assign out_ch.y_out         = out_rsp_r.y_out;
  assign out_ch.prefix_match  = out_rsp_r.prefix_match;
  assign out_ch.wrapped       = out_rsp_r.wrapped;
  assign out_ch.invalid       = out_rsp_r.invalid;

  `GHC_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_take, s1_v_r, "accepted request lost")
  `GHC_ASSERT_SAME(a_invalid_zero, clk, rst_n, out_v_r && out_rsp_r.invalid, out_rsp_r.hash_out == 64'd0 && out_rsp_r.precision_out == 6'd0, "invalid result carries data")
  `GHC_ASSERT_SAME(a_wrap_valid, clk, rst_n, out_v_r && out_rsp_r.wrapped, !out_rsp_r.invalid && out_rsp_r.precision_out != 6'd0, "wrap without a step")
  `GHC_ASSERT_SAME(a_low_masked, clk, rst_n, out_v_r, (out_rsp_r.hash_out & ~top_mask(out_rsp_r.precision_out)) == 64'd0, "hash bits below precision set")
endmodule
`default_nettype wire
